>>> hdl/ptsnap_pkg.sv
// ptsnap_pkg: shared widths, register indexes, config types and helpers
// for the periodic tear-line snap block.
// No dependencies.
package ptsnap_pkg;

	localparam int COORD_W    = 24;
	localparam int SNAP_W     = 25;
	localparam int LINE_W     = 16;
	localparam int MAX_LINES  = 4;
	localparam int LSEL_W     = $clog2(MAX_LINES);
	localparam int COUNT_W    = 3;
	localparam int TABLE_W    = LINE_W * MAX_LINES;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = TABLE_W;
	localparam int DIV_STAGES = COORD_W;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_H = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_V = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_H  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_V  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_H  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_V  = 3'd5;

	typedef struct packed {
		logic [LINE_W-1:0]  period_h;
		logic [LINE_W-1:0]  period_v;
		logic [COUNT_W-1:0] count_h;
		logic [COUNT_W-1:0] count_v;
		logic [TABLE_W-1:0] table_h;
		logic [TABLE_W-1:0] table_v;
	} cfg_t;

	typedef struct packed {
		logic [LINE_W-1:0]  period;
		logic [COUNT_W-1:0] count;
		logic [TABLE_W-1:0] lines;
	} axis_cfg_t;

	function automatic axis_cfg_t axis_view(cfg_t cfg, logic axis);
		axis_cfg_t v;
		if (axis) begin
			v.period = cfg.period_v;
			v.count  = cfg.count_v;
			v.lines  = cfg.table_v;
		end else begin
			v.period = cfg.period_h;
			v.count  = cfg.count_h;
			v.lines  = cfg.table_h;
		end
		return v;
	endfunction

	function automatic logic [LINE_W-1:0] line_at(logic [TABLE_W-1:0] lines,
		logic [LSEL_W-1:0] sel);
		return lines[sel*LINE_W +: LINE_W];
	endfunction

	// counts above the table size saturate
	function automatic logic [COUNT_W-1:0] sat_count(logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] n;
		n = (count > COUNT_W'(MAX_LINES)) ? COUNT_W'(MAX_LINES) : count;
		return n;
	endfunction

endpackage

>>> hdl/ptsnap_cfg.sv
// ptsnap_cfg: configuration register file, one write port, no read-back.
// Depends on ptsnap_pkg.
module ptsnap_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ptsnap_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ptsnap_pkg::CFG_DATA_W-1:0]   cfg_data,
	output ptsnap_pkg::cfg_t                    cfg
);

	ptsnap_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_h <= ptsnap_pkg::LINE_W'(1);
			cfg_q.period_v <= ptsnap_pkg::LINE_W'(1);
			cfg_q.count_h  <= '0;
			cfg_q.count_v  <= '0;
			cfg_q.table_h  <= '0;
			cfg_q.table_v  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptsnap_pkg::REG_PERIOD_H: cfg_q.period_h <= cfg_data[ptsnap_pkg::LINE_W-1:0];
				ptsnap_pkg::REG_PERIOD_V: cfg_q.period_v <= cfg_data[ptsnap_pkg::LINE_W-1:0];
				ptsnap_pkg::REG_COUNT_H:  cfg_q.count_h  <= cfg_data[ptsnap_pkg::COUNT_W-1:0];
				ptsnap_pkg::REG_COUNT_V:  cfg_q.count_v  <= cfg_data[ptsnap_pkg::COUNT_W-1:0];
				ptsnap_pkg::REG_TABLE_H:  cfg_q.table_h  <= cfg_data;
				ptsnap_pkg::REG_TABLE_V:  cfg_q.table_v  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/ptsnap_div.sv
// ptsnap_div: pipelined restoring remainder, one coordinate bit per stage.
// Depends on ptsnap_pkg; period is taken from the live config by axis.
module ptsnap_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  ptsnap_pkg::cfg_t                  cfg,
	input  logic                              in_valid,
	input  logic [ptsnap_pkg::COORD_W-1:0]    coordinate,
	input  logic                              axis,
	output logic                              div_valid,
	output logic [ptsnap_pkg::LINE_W-1:0]     div_rem,
	output logic [ptsnap_pkg::COORD_W-1:0]    div_crd,
	output logic                              div_axis
);

	localparam int N = ptsnap_pkg::DIV_STAGES;
	localparam int W = ptsnap_pkg::LINE_W;

	logic                           vld_s  [N];
	logic [W-1:0]                   rem_s  [N];
	logic [ptsnap_pkg::COORD_W-1:0] crd_s  [N];
	logic                           axis_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                           v_in;
		logic [W-1:0]                   r_in;
		logic [ptsnap_pkg::COORD_W-1:0] c_in;
		logic                           a_in;
		ptsnap_pkg::axis_cfg_t          acfg;
		logic [W:0]                     trial;
		logic [W:0]                     divisor;
		logic [W-1:0]                   r_next;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = '0;
			assign c_in = coordinate;
			assign a_in = axis;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign r_in = rem_s[k-1];
			assign c_in = crd_s[k-1];
			assign a_in = axis_s[k-1];
		end

		assign acfg    = ptsnap_pkg::axis_view(cfg, a_in);
		assign divisor = {1'b0, acfg.period};
		// bring down the next coordinate bit, most significant first
		assign trial   = {r_in, c_in[ptsnap_pkg::COORD_W-1-k]};
		assign r_next  = (trial >= divisor) ? W'(trial - divisor) : W'(trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= r_next;
				crd_s[k]  <= c_in;
				axis_s[k] <= a_in;
			end
		end
	end

	assign div_valid = vld_s[N-1];
	assign div_rem   = rem_s[N-1];
	assign div_crd   = crd_s[N-1];
	assign div_axis  = axis_s[N-1];

endmodule

>>> hdl/ptsnap_pick.sv
// ptsnap_pick: locate the remainder among the tear lines, pick the snap
// offset by the midpoint test, and add it to the period base.
// Depends on ptsnap_pkg; three register stages, the last is the output.
module ptsnap_pick (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  ptsnap_pkg::cfg_t                  cfg,
	input  logic                              div_valid,
	input  logic [ptsnap_pkg::LINE_W-1:0]     div_rem,
	input  logic [ptsnap_pkg::COORD_W-1:0]    div_crd,
	input  logic                              div_axis,
	output logic                              out_valid,
	output logic [ptsnap_pkg::SNAP_W-1:0]     snapped
);

	localparam int W  = ptsnap_pkg::LINE_W;
	localparam int CW = ptsnap_pkg::COUNT_W;
	localparam int SW = ptsnap_pkg::LSEL_W;

	// stage 1: locate
	ptsnap_pkg::axis_cfg_t          acfg1;
	logic [CW-1:0]                  n1;
	logic                           pass1;
	logic [CW-1:0]                  idx1;

	logic                           vld_s1;
	logic                           pass_s1;
	logic [CW-1:0]                  idx_s1;
	logic [W-1:0]                   rem_s1;
	logic [ptsnap_pkg::COORD_W-1:0] base_s1;
	logic                           axis_s1;

	assign acfg1 = ptsnap_pkg::axis_view(cfg, div_axis);
	assign n1    = ptsnap_pkg::sat_count(acfg1.count);
	assign pass1 = (n1 == '0) || (acfg1.period == '0);

	always_comb begin
		idx1 = n1;
		for (int k = ptsnap_pkg::MAX_LINES - 1; k >= 0; k--) begin
			if ((CW'(k) < n1) && (div_rem < ptsnap_pkg::line_at(acfg1.lines, SW'(k))))
				idx1 = CW'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s1 <= pass1;
			idx_s1  <= idx1;
			rem_s1  <= div_rem;
			// with no tear lines, or a zero period that makes the remainder meaningless, keep the coordinate whole
			base_s1 <= pass1 ? div_crd : div_crd - ptsnap_pkg::COORD_W'(div_rem);
			axis_s1 <= div_axis;
		end
	end

	// stage 2: midpoint test
	ptsnap_pkg::axis_cfg_t          acfg2;
	logic [CW-1:0]                  n2;
	logic [W-1:0]                   lo2;
	logic [W-1:0]                   hi2;
	logic [W:0]                     sum2;
	logic [W-1:0]                   mid2;
	logic                           last2;
	logic [W-1:0]                   off2;

	logic                           vld_s2;
	logic [W-1:0]                   off_s2;
	logic [ptsnap_pkg::COORD_W-1:0] base_s2;

	assign acfg2 = ptsnap_pkg::axis_view(cfg, axis_s1);
	assign n2    = ptsnap_pkg::sat_count(acfg2.count);
	assign last2 = (idx_s1 == n2);
	assign lo2   = ptsnap_pkg::line_at(acfg2.lines, SW'(idx_s1 - CW'(1)));
	assign hi2   = last2 ? acfg2.period : ptsnap_pkg::line_at(acfg2.lines, idx_s1[SW-1:0]);
	assign sum2  = {1'b0, lo2} + {1'b0, hi2};
	assign mid2  = sum2[W:1];

	always_comb begin
		if (pass_s1) begin
			off2 = '0;
		end else if ((idx_s1 == '0) || (rem_s1 == '0)) begin
			off2 = ptsnap_pkg::line_at(acfg2.lines, '0);
		end else if (last2) begin
			// past the last line the midpoint itself still snaps down
			off2 = (rem_s1 <= mid2) ? lo2 : hi2;
		end else begin
			off2 = (rem_s1 < mid2) ? lo2 : hi2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			off_s2  <= off2;
			base_s2 <= base_s1;
		end
	end

	// stage 3: final add into the output register
	logic                           vld_s3;
	logic [ptsnap_pkg::SNAP_W-1:0]  snap_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			snap_s3 <= ptsnap_pkg::SNAP_W'(base_s2) + ptsnap_pkg::SNAP_W'(off_s2);
		end
	end

	assign out_valid = vld_s3;
	assign snapped   = snap_s3;

endmodule

>>> hdl/periodic_tearline_snap.sv
// periodic_tearline_snap: snaps a coordinate to the nearest tear line of a
// periodic grid, one beat in and one beat out per cycle when unstalled.
// Depends on ptsnap_pkg, ptsnap_cfg, ptsnap_div and ptsnap_pick.
//
// One coordinate is taken every cycle while the output is not stalled. Each
// passes through the remainder pipeline, which resolves one coordinate
// bit per stage against the axis period, then through stages that locate the
// remainder among the tear lines, apply the midpoint test and add the period
// base into the output register. The whole pipeline advances together, so a
// stall on the output holds every stage and in_ready follows
// (!out_valid || out_ready). Configuration registers are read live by every
// stage and are to be written only while no beat is in flight.
module periodic_tearline_snap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ptsnap_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptsnap_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ptsnap_pkg::COORD_W-1:0]    coordinate,
	input  logic                              axis,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ptsnap_pkg::SNAP_W-1:0]     snapped
);

	ptsnap_pkg::cfg_t                  cfg;
	logic                              adv;
	logic                              div_valid;
	logic [ptsnap_pkg::LINE_W-1:0]     div_rem;
	logic [ptsnap_pkg::COORD_W-1:0]    div_crd;
	logic                              div_axis;

	// whole pipeline moves when the output register is free or being drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	ptsnap_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ptsnap_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.coordinate (coordinate),
		.axis       (axis),
		.div_valid  (div_valid),
		.div_rem    (div_rem),
		.div_crd    (div_crd),
		.div_axis   (div_axis)
	);

	ptsnap_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.div_valid (div_valid),
		.div_rem   (div_rem),
		.div_crd   (div_crd),
		.div_axis  (div_axis),
		.out_valid (out_valid),
		.snapped   (snapped)
	);

endmodule

>>> hdl/ptsnap_checker.sv
// ptsnap_checker: port-level checks for periodic_tearline_snap, with bind.
// Depends on ptsnap_pkg and the top level's ports.
module ptsnap_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [ptsnap_pkg::SNAP_W-1:0]     snapped
);

	localparam logic [ptsnap_pkg::SNAP_W-1:0] SNAP_MAX = 25'd16842750;

	// input side is free exactly when the output register can move
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not track output register state");

	// an offered input beat stays offered until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input beat withdrawn without handshake");

	// base plus one offset never passes the largest reachable value
	a_snap_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (snapped <= SNAP_MAX))
		else $error("snapped result out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(snapped))
		else $error("stalled output beat changed");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("output beat withdrawn without handshake");

endmodule

bind periodic_tearline_snap ptsnap_checker u_ptsnap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.snapped   (snapped)
);

>>> bench/periodic_tearline_snap_test.sv
// periodic_tearline_snap_test: self-checking bench for the periodic tear-line snap block,
// with a scoreboard that computes each snapped coordinate from its own copy of the registers.
// Depends on ptsnap_pkg and periodic_tearline_snap.
module periodic_tearline_snap_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_DEPTH = 27;
	localparam logic [ptsnap_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [ptsnap_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic AXIS_H = 1'b0;
	localparam logic AXIS_V = 1'b1;

	typedef struct {
		logic [ptsnap_pkg::COORD_W-1:0] coord;
		logic                           ax;
		logic [ptsnap_pkg::SNAP_W-1:0]  value;
	} snap_expect_t;

	class snap_scoreboard;
		logic [ptsnap_pkg::LINE_W-1:0]  period [2];
		logic [ptsnap_pkg::COUNT_W-1:0] count [2];
		logic [ptsnap_pkg::TABLE_W-1:0] lines [2];
		snap_expect_t                   pending_snaps [$];
		int                             mismatches;
		int                             checked;

		function new();
			period = '{16'd1, 16'd1};
			count = '{3'd0, 3'd0};
			lines = '{64'd0, 64'd0};
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_register(logic [ptsnap_pkg::CFG_IDX_W-1:0] idx,
			logic [ptsnap_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ptsnap_pkg::REG_PERIOD_H: period[AXIS_H] = data[ptsnap_pkg::LINE_W-1:0];
				ptsnap_pkg::REG_PERIOD_V: period[AXIS_V] = data[ptsnap_pkg::LINE_W-1:0];
				ptsnap_pkg::REG_COUNT_H:  count[AXIS_H] = data[ptsnap_pkg::COUNT_W-1:0];
				ptsnap_pkg::REG_COUNT_V:  count[AXIS_V] = data[ptsnap_pkg::COUNT_W-1:0];
				ptsnap_pkg::REG_TABLE_H:  lines[AXIS_H] = data;
				ptsnap_pkg::REG_TABLE_V:  lines[AXIS_V] = data;
				default: ;
			endcase
		endfunction

		function logic [ptsnap_pkg::SNAP_W-1:0] snap_coordinate(
			logic [ptsnap_pkg::COORD_W-1:0] c, logic ax);
			int unsigned per, n, rem, base, sel, lo, hi;
			int unsigned t [ptsnap_pkg::MAX_LINES];
			per = period[ax];
			n = (count[ax] > ptsnap_pkg::MAX_LINES) ? ptsnap_pkg::MAX_LINES : count[ax];
			for (int j = 0; j < ptsnap_pkg::MAX_LINES; j++)
				t[j] = lines[ax][j*ptsnap_pkg::LINE_W +: ptsnap_pkg::LINE_W];
			if (n == 0 || per == 0)
				return ptsnap_pkg::SNAP_W'(c);
			rem = c % per;
			base = c - rem;
			// first line strictly above the remainder, n if none
			sel = n;
			for (int j = 0; j < n; j++)
				if (sel == n && rem < t[j])
					sel = j;
			if (sel == 0 || rem == 0)
				return ptsnap_pkg::SNAP_W'(base + t[0]);
			lo = t[sel-1];
			if (sel == n)
				return ptsnap_pkg::SNAP_W'((rem <= (lo + per) / 2) ? base + lo : base + per);
			hi = t[sel];
			return ptsnap_pkg::SNAP_W'((rem < (lo + hi) / 2) ? base + lo : base + hi);
		endfunction

		function void note_coordinate(logic [ptsnap_pkg::COORD_W-1:0] c, logic ax);
			snap_expect_t e;
			e.coord = c;
			e.ax = ax;
			e.value = snap_coordinate(c, ax);
			pending_snaps.push_back(e);
		endfunction

		function void check_snapped(logic [ptsnap_pkg::SNAP_W-1:0] got);
			snap_expect_t e;
			if (pending_snaps.size() == 0) begin
				$display("%0t: unexpected result beat, expected none got %0d", $time, got);
				mismatches++;
				return;
			end
			e = pending_snaps.pop_front();
			checked++;
			if (got !== e.value) begin
				$display("%0t: snapped mismatch (coordinate %0d axis %0d), expected %0d got %0d",
					$time, e.coord, e.ax, e.value, got);
				mismatches++;
			end
		endfunction
	endclass

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_we;
	logic [ptsnap_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [ptsnap_pkg::CFG_DATA_W-1:0]    cfg_data;
	logic                                 in_valid;
	logic                                 in_ready;
	logic [ptsnap_pkg::COORD_W-1:0]       coordinate;
	logic                                 axis;
	logic                                 out_valid;
	logic                                 out_ready;
	logic [ptsnap_pkg::SNAP_W-1:0]        snapped;

	snap_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int beats_sent = 0;
	int cfg_writes = 0;

	periodic_tearline_snap i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.coordinate (coordinate),
		.axis       (axis),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.snapped    (snapped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("periodic_tearline_snap regression: fail");
		$finish;
	end

	// receiver: random stalls, or one long hold-off counted here
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_coordinate(coordinate, axis);
			if (out_valid && out_ready)
				sb.check_snapped(snapped);
		end
	end

	task automatic write_reg(input logic [ptsnap_pkg::CFG_IDX_W-1:0] idx,
		input logic [ptsnap_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_register(idx, data);
		cfg_writes++;
	endtask

	task automatic send_beat(input logic [ptsnap_pkg::COORD_W-1:0] c, input logic ax);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		coordinate <= c;
		axis <= ax;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// sender pauses until every result is back, then lets the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_snaps.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 3) @(posedge clk);
	endtask

	task automatic random_config();
		logic [ptsnap_pkg::LINE_W-1:0]     per;
		logic [ptsnap_pkg::COUNT_W-1:0]    cnt;
		logic [ptsnap_pkg::TABLE_W-1:0]    tbl;
		logic [ptsnap_pkg::CFG_DATA_W-1:0] data;
		logic [ptsnap_pkg::LINE_W-1:0]     t [ptsnap_pkg::MAX_LINES];
		logic [ptsnap_pkg::LINE_W-1:0]     tmp;
		for (int a = 0; a < 2; a++) begin
			case ($urandom_range(0, 7))
				0: per = '0;
				1: per = '1;
				2: per = 16'd1;
				3, 4: per = ptsnap_pkg::LINE_W'($urandom_range(2, 40));
				default: per = ptsnap_pkg::LINE_W'($urandom_range(2, 65535));
			endcase
			cnt = ($urandom_range(0, 9) > 7) ? ptsnap_pkg::COUNT_W'(ptsnap_pkg::MAX_LINES)
				: ptsnap_pkg::COUNT_W'($urandom_range(0, 7));
			if ($urandom_range(0, 5) == 0) begin
				tbl = {$urandom, $urandom};
			end else begin
				// well-formed: ascending offsets inside the period
				for (int j = 0; j < ptsnap_pkg::MAX_LINES; j++)
					t[j] = (per == 0) ? ptsnap_pkg::LINE_W'($urandom)
						: ptsnap_pkg::LINE_W'($urandom_range(0, per - 1));
				for (int i = 0; i < ptsnap_pkg::MAX_LINES - 1; i++)
					for (int j = 0; j < ptsnap_pkg::MAX_LINES - 1 - i; j++)
						if (t[j] > t[j+1]) begin
							tmp = t[j];
							t[j] = t[j+1];
							t[j+1] = tmp;
						end
				tbl = {t[3], t[2], t[1], t[0]};
			end
			data = {$urandom, $urandom};
			data[ptsnap_pkg::LINE_W-1:0] = per;
			write_reg(a ? ptsnap_pkg::REG_PERIOD_V : ptsnap_pkg::REG_PERIOD_H, data);
			data = {$urandom, $urandom};
			data[ptsnap_pkg::COUNT_W-1:0] = cnt;
			write_reg(a ? ptsnap_pkg::REG_COUNT_V : ptsnap_pkg::REG_COUNT_H, data);
			write_reg(a ? ptsnap_pkg::REG_TABLE_V : ptsnap_pkg::REG_TABLE_H, tbl);
		end
	endtask

	// coordinates aimed at tear lines, midpoints and period origins
	function automatic logic [ptsnap_pkg::COORD_W-1:0] pick_coordinate(logic ax);
		int unsigned per, r, j, lo_t, hi_t, qmax;
		per = sb.period[ax];
		if (per == 0 || $urandom_range(0, 4) == 0)
			return ptsnap_pkg::COORD_W'($urandom);
		j = $urandom_range(0, ptsnap_pkg::MAX_LINES - 1);
		lo_t = sb.lines[ax][j*ptsnap_pkg::LINE_W +: ptsnap_pkg::LINE_W];
		hi_t = (j == ptsnap_pkg::MAX_LINES - 1) ? per
			: sb.lines[ax][(j+1)*ptsnap_pkg::LINE_W +: ptsnap_pkg::LINE_W];
		case ($urandom_range(0, 3))
			0: r = $urandom;
			1: r = lo_t + $urandom_range(0, 2) - 1;
			2: r = (lo_t + hi_t) / 2 + $urandom_range(0, 2) - 1;
			default: r = 0;
		endcase
		r = r % per;
		qmax = (32'hFF_FFFF - r) / per;
		return ptsnap_pkg::COORD_W'(($urandom_range(0, 7) == 0 ? qmax
			: $urandom_range(0, qmax)) * per + r);
	endfunction

	initial begin
		logic ax;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		coordinate = '0;
		axis = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: no tear lines, coordinates pass through
		send_beat(24'd0, AXIS_H);
		send_beat(24'hFF_FFFF, AXIS_V);
		send_beat(24'h55_5555, AXIS_H);
		wait_idle();

		// sorted tables: origin, below first line, between lines, past last line
		write_reg(ptsnap_pkg::REG_PERIOD_H, 64'd10);
		write_reg(ptsnap_pkg::REG_COUNT_H, 64'd3);
		write_reg(ptsnap_pkg::REG_TABLE_H, {16'd0, 16'd7, 16'd5, 16'd2});
		write_reg(ptsnap_pkg::REG_PERIOD_V, 64'hFFFF);
		write_reg(ptsnap_pkg::REG_COUNT_V, 64'd4);
		write_reg(ptsnap_pkg::REG_TABLE_V, {16'd60000, 16'd30000, 16'd1000, 16'd100});
		send_beat(24'd20, AXIS_H);
		send_beat(24'd21, AXIS_H);
		send_beat(24'd22, AXIS_H);
		send_beat(24'd23, AXIS_H);
		send_beat(24'd28, AXIS_H);
		send_beat(24'd29, AXIS_H);
		send_beat(24'hFF_FFFF, AXIS_H);
		send_beat(24'd0, AXIS_V);
		send_beat(24'hFF_FFFF, AXIS_V);
		send_beat(24'd65534, AXIS_V);
		send_beat(24'd62767, AXIS_V);
		wait_idle();

		// zero period, saturated count, unsorted table with lines beyond the period
		write_reg(ptsnap_pkg::REG_PERIOD_H, 64'd0);
		write_reg(ptsnap_pkg::REG_COUNT_H, 64'd7);
		write_reg(ptsnap_pkg::REG_PERIOD_V, 64'd7);
		write_reg(ptsnap_pkg::REG_COUNT_V, 64'd7);
		write_reg(ptsnap_pkg::REG_TABLE_V, {16'hFFFF, 16'd3, 16'd9, 16'd5});
		send_beat(24'd12345, AXIS_H);
		send_beat(24'hFF_FFFF, AXIS_H);
		send_beat(24'd0, AXIS_V);
		send_beat(24'd3, AXIS_V);
		send_beat(24'd6, AXIS_V);
		send_beat(24'hFF_FFFF, AXIS_V);
		wait_idle();

		// unused indexes must leave every register alone
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		send_beat(24'd13, AXIS_V);
		send_beat(24'd100, AXIS_H);
		wait_idle();

		for (int ph = 0; ph < 9; ph++) begin
			random_config();
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			for (int k = 0; k < 45; k++) begin
				ax = $urandom_range(0, 1);
				send_beat(pick_coordinate(ax), ax);
			end
			wait_idle();
		end

		// long output hold-off while the sender keeps offering, fills the pipeline
		random_config();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_len = 200;
		for (int k = 0; k < 60; k++) begin
			ax = $urandom_range(0, 1);
			send_beat(pick_coordinate(ax), ax);
		end
		wait_idle();

		if (sb.pending_snaps.size() != 0) begin
			$display("%0t: %0d results never arrived, expected none got %0d", $time,
				sb.pending_snaps.size(), sb.pending_snaps.size());
			sb.mismatches++;
		end
		$display("covered %0d coordinates on both axes over %0d register writes,", beats_sent,
			cfg_writes);
		$display("incl. zero periods, saturated counts, unsorted tables and a full stall; %0d checked",
			sb.checked);
		if (sb.mismatches == 0)
			$display("periodic_tearline_snap regression: pass");
		else
			$display("periodic_tearline_snap regression: fail");
		$finish;
	end

endmodule
